// File: hdl/ctsb_pkg.sv
// Shared types, codes and default sizes for the COO to CSF builder.
package ctsb_pkg;

   // Default sizes of the block.
   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int COORD_BITS_DEF  = 32;
   localparam int MAX_MODES_DEF   = 3;

   // Fixed widths of the transaction fields.
   localparam int CMD_W   = 2;
   localparam int WORD_W  = 32;
   localparam int LEVEL_W = 2;
   localparam int POS_W   = 11;
   localparam int LEN_W   = 11;
   localparam int STAT_W  = 2;
   localparam int MODE_W  = 2;

   // Reset value of the mode count register.
   localparam logic [MODE_W-1:0] MODE_COUNT_RESET = 2'd3;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // Array kinds for reads.
   localparam logic KIND_PTR = 1'b0;
   localparam logic KIND_IDX = 1'b1;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] ST_UNBUILT = 2'd3;

   // Request transaction.
   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [WORD_W-1:0]  coord_0;
      logic [WORD_W-1:0]  coord_1;
      logic [WORD_W-1:0]  coord_2;
      logic [LEVEL_W-1:0] read_level;
      logic               read_kind;
      logic [POS_W-1:0]   read_position;
   } req_type;

   // Response transaction.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] read_word;
      logic [LEN_W-1:0]  array_length;
      logic [LEN_W-1:0]  entry_count;
   } rsp_type;

endpackage

// File: hdl/ctsb_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module ctsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ctsb_key_cmp.sv
// Lexicographic less-than compare of two coordinate records over the used modes.
module ctsb_key_cmp #(
   parameter int MODES = 3,
   parameter int CB    = 32,
   parameter int LW    = 2
) (
   input  logic [MODES*CB-1:0] key_a,
   input  logic [MODES*CB-1:0] key_b,
   input  logic [LW-1:0]       last_level,
   output logic                less
);

   logic [MODES*CB-1:0] mask_a;
   logic [MODES*CB-1:0] mask_b;

   // Modes past the last used level do not take part in the order.
   always_comb begin
      for (int k = 0; k < MODES; k++) begin
         if (k <= int'(last_level)) begin
            mask_a[(MODES-1-k)*CB +: CB] = key_a[(MODES-1-k)*CB +: CB];
            mask_b[(MODES-1-k)*CB +: CB] = key_b[(MODES-1-k)*CB +: CB];
         end else begin
            mask_a[(MODES-1-k)*CB +: CB] = '0;
            mask_b[(MODES-1-k)*CB +: CB] = '0;
         end
      end
   end

   // Mode 0 sits in the top bits, so one compare gives the lexicographic order.
   assign less = (mask_a < mask_b);

endmodule

// File: hdl/coo_to_csf_builder_core.sv
// An append or unknown command answers in the cycle after acceptance; a read answers through
// the pending register and S_RESP. Throughput: appends and unknown commands 1 per cycle while
// the output is not stalled; a read holds off new requests until its answer is registered.
// A build insertion-sorts the store into the sort buffer, then compresses it level by level.
// Reset is synchronous and active high; it empties the store, marks the arrays unbuilt and zeroes their lengths.
module coo_to_csf_builder_core
   import ctsb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int MAX_MODES   = MAX_MODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data
);

   localparam int E    = MAX_ENTRIES;
   localparam int CB   = (COORD_BITS < WORD_W) ? COORD_BITS : WORD_W;
   localparam int RW   = MAX_MODES * CB;
   localparam int CW   = $clog2(E + 1);
   localparam int EAW  = (E > 1) ? $clog2(E) : 1;
   localparam int PW   = $clog2(E + 2);
   localparam int LW   = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int ID   = MAX_MODES * E;
   localparam int IAW  = (ID > 1) ? $clog2(ID) : 1;
   localparam int PD   = MAX_MODES * (E + 1);
   localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
   localparam int CMPW = (PW > POS_W) ? PW : POS_W;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_SO_KEY   = 10'b0000000010,
      S_SO_KEYW  = 10'b0000000100,
      S_SO_CMP   = 10'b0000001000,
      S_SO_PLACE = 10'b0000010000,
      S_CP_INIT  = 10'b0000100000,
      S_CP_RD    = 10'b0001000000,
      S_CP_LVL   = 10'b0010000000,
      S_CP_CLOSE = 10'b0100000000,
      S_RESP     = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                built_ff, built_in;
   logic [PW-1:0]       plen_ff [MAX_MODES];
   logic [PW-1:0]       plen_in [MAX_MODES];
   logic [PW-1:0]       ilen_ff [MAX_MODES];
   logic [PW-1:0]       ilen_in [MAX_MODES];
   logic [CB-1:0]       prev_ff [MAX_MODES];
   logic [CB-1:0]       prev_in [MAX_MODES];
   logic [LW-1:0]       last_ff, last_in;
   logic [LW-1:0]       lvl_ff, lvl_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [RW-1:0]       key_ff, key_in;
   logic                first_ff, first_in;
   logic                split_ff, split_in;
   rsp_type             pend_ff, pend_in;
   logic                pend_rd_ff, pend_rd_in;
   logic                pend_kind_ff, pend_kind_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Memory ports.
   logic                st_wr_en, st_rd_en;
   logic [EAW-1:0]      st_wr_addr, st_rd_addr;
   logic [RW-1:0]       st_wr_data, st_rd_data;
   logic                bf_wr_en, bf_rd_en;
   logic [EAW-1:0]      bf_wr_addr, bf_rd_addr;
   logic [RW-1:0]       bf_wr_data, bf_rd_data;
   logic                ix_wr_en, ix_rd_en;
   logic [IAW-1:0]      ix_wr_addr, ix_rd_addr;
   logic [CB-1:0]       ix_wr_data, ix_rd_data;
   logic                pt_wr_en, pt_rd_en;
   logic [PAW-1:0]      pt_wr_addr, pt_rd_addr;
   logic [PW-1:0]       pt_wr_data, pt_rd_data;

   logic                key_less;
   logic [LW-1:0]       last_c;
   logic [WORD_W-1:0]   coord_in [3];
   logic [RW-1:0]       new_rec;
   logic [CW-1:0]       im1, jm1, jm2;
   logic                accept, rsp_free, store_full;

   // Coordinate stores and compressed arrays.
   ctsb_ram #(.WIDTH(RW), .DEPTH(E)) u_store (
      .clock(clock), .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_data),
      .rd_en(st_rd_en), .rd_addr(st_rd_addr), .rd_data(st_rd_data)
   );

   ctsb_ram #(.WIDTH(RW), .DEPTH(E)) u_sort_buf (
      .clock(clock), .wr_en(bf_wr_en), .wr_addr(bf_wr_addr), .wr_data(bf_wr_data),
      .rd_en(bf_rd_en), .rd_addr(bf_rd_addr), .rd_data(bf_rd_data)
   );

   ctsb_ram #(.WIDTH(CB), .DEPTH(ID)) u_index_mem (
      .clock(clock), .wr_en(ix_wr_en), .wr_addr(ix_wr_addr), .wr_data(ix_wr_data),
      .rd_en(ix_rd_en), .rd_addr(ix_rd_addr), .rd_data(ix_rd_data)
   );

   ctsb_ram #(.WIDTH(PW), .DEPTH(PD)) u_pointer_mem (
      .clock(clock), .wr_en(pt_wr_en), .wr_addr(pt_wr_addr), .wr_data(pt_wr_data),
      .rd_en(pt_rd_en), .rd_addr(pt_rd_addr), .rd_data(pt_rd_data)
   );

   // Sort comparator: latched key against the sort buffer word just read.
   ctsb_key_cmp #(.MODES(MAX_MODES), .CB(CB), .LW(LW)) u_key_cmp (
      .key_a(key_ff), .key_b(bf_rd_data), .last_level(last_ff), .less(key_less)
   );

   // Appended record, each coordinate cut to the stored width.
   always_comb begin
      coord_in[0] = req_data.coord_0;
      coord_in[1] = req_data.coord_1;
      coord_in[2] = req_data.coord_2;
      for (int k = 0; k < MAX_MODES; k++) begin
         new_rec[(MAX_MODES-1-k)*CB +: CB] = coord_in[k][CB-1:0];
      end
   end

   // Last used level from the mode count register.
   always_comb begin
      if (mode_ff == 2'd0) begin
         last_c = '0;
      end else if (32'(mode_ff) > MAX_MODES) begin
         last_c = LW'(MAX_MODES - 1);
      end else begin
         last_c = LW'(mode_ff - 2'd1);
      end
   end

   assign im1        = i_ff - CW'(1);
   assign jm1        = j_ff - CW'(1);
   assign jm2        = j_ff - CW'(2);
   assign store_full = (cnt_ff == CW'(E));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Reads and builds answer later, so only immediate answers need a free output register.
   assign req_stall = (state_ff != S_IDLE) ||
                      (rsp_valid_ff && rsp_stall &&
                       req_data.command != CMD_READ && req_data.command != CMD_BUILD);
   assign accept    = req_valid && !req_stall;

   // Control, build sequencer and memory port selection.
   always_comb begin
      logic [CB-1:0]    lvl_c;
      logic             split_c;
      logic [LW-1:0]    nxt_lvl;
      logic             lvl_ok;
      logic [LW-1:0]    rd_lvl;
      logic [PW-1:0]    rd_len;
      logic [STAT_W-1:0] rd_stat;

      state_in     = state_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      built_in     = built_ff;
      plen_in      = plen_ff;
      ilen_in      = ilen_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      lvl_in       = lvl_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_in       = key_ff;
      first_in     = first_ff;
      split_in     = split_ff;
      pend_in      = pend_ff;
      pend_rd_in   = pend_rd_ff;
      pend_kind_in = pend_kind_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      st_wr_en   = 1'b0;
      st_wr_addr = cnt_ff[EAW-1:0];
      st_wr_data = new_rec;
      st_rd_en   = 1'b0;
      st_rd_addr = i_ff[EAW-1:0];
      bf_wr_en   = 1'b0;
      bf_wr_addr = j_ff[EAW-1:0];
      bf_wr_data = key_ff;
      bf_rd_en   = 1'b0;
      bf_rd_addr = i_ff[EAW-1:0];
      ix_wr_en   = 1'b0;
      ix_wr_addr = '0;
      ix_wr_data = '0;
      ix_rd_en   = 1'b0;
      ix_rd_addr = '0;
      pt_wr_en   = 1'b0;
      pt_wr_addr = '0;
      pt_wr_data = '0;
      pt_rd_en   = 1'b0;
      pt_rd_addr = '0;

      lvl_c   = bf_rd_data[(MAX_MODES-1-int'(lvl_ff))*CB +: CB];
      split_c = split_ff || (lvl_c != prev_ff[lvl_ff]);
      nxt_lvl = lvl_ff + LW'(1);

      // Read lookup: length of the selected array and the resulting status.
      lvl_ok = (32'(req_data.read_level) < MAX_MODES);
      rd_lvl = req_data.read_level[LW-1:0];
      rd_len = '0;
      if (lvl_ok) begin
         rd_len = (req_data.read_kind == KIND_IDX) ? ilen_ff[rd_lvl] : plen_ff[rd_lvl];
      end
      if (!built_ff) begin
         rd_stat = ST_UNBUILT;
         rd_len  = '0;
      end else if (CMPW'(req_data.read_position) >= CMPW'(rd_len)) begin
         rd_stat = ST_RANGE;
      end else begin
         rd_stat = ST_OK;
      end

      // The user must issue configuration writes only while idle; the block itself does not enforce this.
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_APPEND: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.read_word    = '0;
                     rsp_in.array_length = '0;
                     if (store_full) begin
                        rsp_in.status      = ST_FULL;
                        rsp_in.entry_count = LEN_W'(cnt_ff);
                     end else begin
                        st_wr_en           = 1'b1;
                        cnt_in             = cnt_ff + CW'(1);
                        rsp_in.status      = ST_OK;
                        rsp_in.entry_count = LEN_W'(cnt_ff + CW'(1));
                     end
                  end
                  CMD_BUILD: begin
                     last_in  = last_c;
                     i_in     = '0;
                     state_in = S_SO_KEY;
                  end
                  CMD_READ: begin
                     pend_in.status       = rd_stat;
                     pend_in.read_word    = '0;
                     pend_in.array_length = LEN_W'(rd_len);
                     pend_in.entry_count  = LEN_W'(cnt_ff);
                     pend_rd_in           = 1'b1;
                     pend_kind_in         = req_data.read_kind;
                     ix_rd_en   = (rd_stat == ST_OK) && (req_data.read_kind == KIND_IDX);
                     pt_rd_en   = (rd_stat == ST_OK) && (req_data.read_kind == KIND_PTR);
                     ix_rd_addr = IAW'(IAW'(rd_lvl) * IAW'(E) + IAW'(req_data.read_position));
                     pt_rd_addr = PAW'(PAW'(rd_lvl) * PAW'(E + 1) +
                                       PAW'(req_data.read_position));
                     state_in   = S_RESP;
                  end
                  default: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.status       = ST_OK;
                     rsp_in.read_word    = '0;
                     rsp_in.array_length = '0;
                     rsp_in.entry_count  = LEN_W'(cnt_ff);
                  end
               endcase
            end
         end

         // Insertion sort: fetch the next stored record as the key.
         S_SO_KEY: begin
            if (i_ff == cnt_ff) begin
               state_in = S_CP_INIT;
            end else begin
               st_rd_en = 1'b1;
               state_in = S_SO_KEYW;
            end
         end

         S_SO_KEYW: begin
            key_in = st_rd_data;
            j_in   = i_ff;
            if (i_ff == '0) begin
               bf_wr_en   = 1'b1;
               bf_wr_addr = '0;
               bf_wr_data = st_rd_data;
               i_in       = i_ff + CW'(1);
               state_in   = S_SO_KEY;
            end else begin
               bf_rd_en   = 1'b1;
               bf_rd_addr = im1[EAW-1:0];
               state_in   = S_SO_CMP;
            end
         end

         // Shift larger records up one place until the key's slot is found.
         S_SO_CMP: begin
            bf_wr_en = 1'b1;
            if (key_less) begin
               bf_wr_data = bf_rd_data;
               j_in       = jm1;
               if (jm1 == '0) begin
                  state_in = S_SO_PLACE;
               end else begin
                  bf_rd_en   = 1'b1;
                  bf_rd_addr = jm2[EAW-1:0];
               end
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_SO_KEY;
            end
         end

         S_SO_PLACE: begin
            bf_wr_en = 1'b1;
            i_in     = i_ff + CW'(1);
            state_in = S_SO_KEY;
         end

         // Compression setup: pointer array 0 opens with a zero.
         S_CP_INIT: begin
            for (int k = 0; k < MAX_MODES; k++) begin
               plen_in[k] = '0;
               ilen_in[k] = '0;
            end
            plen_in[0] = PW'(1);
            pt_wr_en   = 1'b1;
            i_in       = '0;
            first_in   = 1'b1;
            state_in   = S_CP_RD;
         end

         S_CP_RD: begin
            lvl_in = '0;
            if (i_ff == cnt_ff) begin
               state_in = S_CP_CLOSE;
            end else begin
               bf_rd_en = 1'b1;
               split_in = first_ff;
               state_in = S_CP_LVL;
            end
         end

         // One level of the sorted entry per cycle.
         S_CP_LVL: begin
            split_in = split_c;
            if (split_c) begin
               ix_wr_en       = 1'b1;
               ix_wr_addr     = IAW'(IAW'(lvl_ff) * IAW'(E) + IAW'(ilen_ff[lvl_ff]));
               ix_wr_data     = lvl_c;
               ilen_in[lvl_ff] = ilen_ff[lvl_ff] + PW'(1);
               prev_in[lvl_ff] = lvl_c;
               if (lvl_ff != last_ff) begin
                  pt_wr_en         = 1'b1;
                  pt_wr_addr       = PAW'(PAW'(nxt_lvl) * PAW'(E + 1) +
                                          PAW'(plen_ff[nxt_lvl]));
                  pt_wr_data       = ilen_ff[nxt_lvl];
                  plen_in[nxt_lvl] = plen_ff[nxt_lvl] + PW'(1);
               end
            end
            if (lvl_ff == last_ff) begin
               i_in     = i_ff + CW'(1);
               first_in = 1'b0;
               state_in = S_CP_RD;
            end else begin
               lvl_in = nxt_lvl;
            end
         end

         // Close every used pointer array with its level's index count.
         S_CP_CLOSE: begin
            pt_wr_en        = 1'b1;
            pt_wr_addr      = PAW'(PAW'(lvl_ff) * PAW'(E + 1) + PAW'(plen_ff[lvl_ff]));
            pt_wr_data      = ilen_ff[lvl_ff];
            plen_in[lvl_ff] = plen_ff[lvl_ff] + PW'(1);
            if (lvl_ff == last_ff) begin
               built_in             = 1'b1;
               pend_in.status       = ST_OK;
               pend_in.read_word    = '0;
               pend_in.array_length = '0;
               pend_in.entry_count  = LEN_W'(cnt_ff);
               pend_rd_in           = 1'b0;
               state_in             = S_RESP;
            end else begin
               lvl_in = nxt_lvl;
            end
         end

         // Hand the pending result to the output register once it is free.
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               if (pend_rd_ff && pend_ff.status == ST_OK) begin
                  rsp_in.read_word = (pend_kind_ff == KIND_IDX) ? WORD_W'(ix_rd_data)
                                                                : WORD_W'(pt_rd_data);
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_COUNT_RESET;
         cnt_ff       <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_MODES; k++) begin
            plen_ff[k] <= '0;
            ilen_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
         plen_ff      <= plen_in;
         ilen_ff      <= ilen_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      prev_ff      <= prev_in;
      last_ff      <= last_in;
      lvl_ff       <= lvl_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      key_ff       <= key_in;
      first_ff     <= first_in;
      split_ff     <= split_in;
      pend_ff      <= pend_in;
      pend_rd_ff   <= pend_rd_in;
      pend_kind_ff <= pend_kind_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/ctsb_checker.sv
// Port-level checker for the COO to CSF builder and its bind to the top level.
module ctsb_checker
   import ctsb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input req_type           req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsp_type           rsp_data
);

   // A stalled request transaction holds.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // A stalled response transaction holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Only a successful read carries a word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.read_word == '0)
      else $error("nonzero word on a failed transaction");

   // A read before any build reports no array length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_UNBUILT |-> rsp_data.array_length == '0)
      else $error("array length given before build");

   // A dropped append reports no word and no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         rsp_data.array_length == '0 && rsp_data.read_word == '0)
      else $error("dropped append carries read data");

endmodule

bind coo_to_csf_builder_core ctsb_checker u_ctsb_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

// File: tb/coo_to_csf_builder_core_test.sv
// Self-checking testbench for the COO to CSF builder core.
`timescale 1ns / 1ps

module coo_to_csf_builder_core_test;
   import ctsb_pkg::*;

   // Command code that the block ignores.
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
   localparam int STORE_DEPTH = MAX_ENTRIES_DEF;
   localparam int LEVELS      = MAX_MODES_DEF;
   localparam int IDLE_LIMIT  = 3000000;
   localparam int PHASE_ITEMS = 25;

   // Scoreboard: predicts each response from its own copy of the builder state.
   class csf_scoreboard;
      logic [WORD_W-1:0] store [STORE_DEPTH][3];
      logic [WORD_W-1:0] index_word [LEVELS][STORE_DEPTH];
      logic [LEN_W-1:0]  pointer_word [LEVELS][STORE_DEPTH+1];
      int                lengths [LEVELS][2];
      int                perm [STORE_DEPTH];
      logic [WORD_W-1:0] last_coord [3];
      int                loaded;
      bit                built;
      logic [MODE_W-1:0] mode_reg;
      rsp_type           expected_rsp [$];
      int                errors;
      int                checked;
      int                builds;
      int                drops;

      function new();
         loaded = 0;
         built = 0;
         mode_reg = MODE_COUNT_RESET;
         errors = 0;
         checked = 0;
         builds = 0;
         drops = 0;
         foreach (lengths[l, k]) lengths[l][k] = 0;
      endfunction

      function int used_levels();
         if (mode_reg == 0) return 1;
         if (mode_reg > LEVELS) return LEVELS;
         return mode_reg;
      endfunction

      // Lexicographic order over the first m coordinates.
      function bit coord_less(int a, int b, int m);
         for (int i = 0; i < m; i++) begin
            if (store[a][i] != store[b][i]) return store[a][i] < store[b][i];
         end
         return 0;
      endfunction

      // Sort the store and compress it level by level.
      function void compress();
         int m;
         int e;
         int key;
         int j;
         bit split;
         m = used_levels();
         foreach (lengths[l, k]) lengths[l][k] = 0;
         for (int i = 0; i < loaded; i++) perm[i] = i;
         for (int i = 1; i < loaded; i++) begin
            key = perm[i];
            j = i;
            while (j > 0 && coord_less(key, perm[j-1], m)) begin
               perm[j] = perm[j-1];
               j--;
            end
            perm[j] = key;
         end
         pointer_word[0][0] = 0;
         lengths[0][0] = 1;
         for (int i = 0; i < loaded; i++) begin
            e = perm[i];
            split = (i == 0);
            for (int l = 0; l < m; l++) begin
               if (split || store[e][l] != last_coord[l]) begin
                  split = 1;
                  index_word[l][lengths[l][1]] = store[e][l];
                  lengths[l][1]++;
                  if (l + 1 < m) begin
                     pointer_word[l+1][lengths[l+1][0]] = LEN_W'(lengths[l+1][1]);
                     lengths[l+1][0]++;
                  end
                  last_coord[l] = store[e][l];
               end
            end
         end
         // Close every pointer array with its level's index count.
         for (int l = 0; l < m; l++) begin
            pointer_word[l][lengths[l][0]] = LEN_W'(lengths[l][1]);
            lengths[l][0]++;
         end
         built = 1;
         builds++;
      endfunction

      // Length of an array as the read path sees it now.
      function int array_len(logic [LEVEL_W-1:0] lvl, logic kind);
         if (lvl >= LEVELS) return 0;
         return lengths[lvl][kind];
      endfunction

      // Notes an accepted request transaction and queues its response.
      function void note(req_type t);
         rsp_type r;
         int len;
         r = '0;
         case (t.command)
            CMD_APPEND: begin
               if (loaded < STORE_DEPTH) begin
                  store[loaded][0] = t.coord_0;
                  store[loaded][1] = t.coord_1;
                  store[loaded][2] = t.coord_2;
                  loaded++;
               end else begin
                  r.status = ST_FULL;
                  drops++;
               end
            end
            CMD_BUILD: compress();
            CMD_READ: begin
               if (!built) begin
                  r.status = ST_UNBUILT;
               end else begin
                  len = array_len(t.read_level, t.read_kind);
                  r.array_length = LEN_W'(len);
                  if (t.read_position >= len) r.status = ST_RANGE;
                  else if (t.read_kind == KIND_PTR)
                     r.read_word = WORD_W'(pointer_word[t.read_level][t.read_position]);
                  else
                     r.read_word = index_word[t.read_level][t.read_position];
               end
            end
            default: ;
         endcase
         r.entry_count = LEN_W'(loaded);
         expected_rsp = {expected_rsp, r};
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 20) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      // Compares a response transaction with the oldest expectation.
      task check(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            report($sformatf("unexpected response %h", got));
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         if (got.status !== want.status)
            report($sformatf("#%0d status %0d, want %0d", checked, got.status, want.status));
         if (got.read_word !== want.read_word)
            report($sformatf("#%0d read_word %h, want %h", checked, got.read_word,
                             want.read_word));
         if (got.array_length !== want.array_length)
            report($sformatf("#%0d array_length %0d, want %0d", checked, got.array_length,
                             want.array_length));
         if (got.entry_count !== want.entry_count)
            report($sformatf("#%0d entry_count %0d, want %0d", checked, got.entry_count,
                             want.entry_count));
      endtask
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   rsp_type           rsp_data;
   logic              csr_wr_en = 0;
   logic [MODE_W-1:0] csr_wr_data = '0;

   csf_scoreboard sb = new();
   bit            no_gaps = 0;
   int            stall_hold = 0;
   int            stall_roll;
   int            idle_cycles = 0;
   int            items_sent = 0;
   logic [21:0]   row_counter = 0;
   logic [WORD_W-1:0] last_row = 0;

   coo_to_csf_builder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Response side: check accepted transactions and stall at random.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) sb.check(rsp_data);
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall <= 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (no_gaps || stall_roll < 70) begin
            rsp_stall <= 0;
         end else if (stall_roll < 95) begin
            rsp_stall <= 1;
            stall_hold <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1;
            stall_hold <= $urandom_range(5, 40);
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("coo_to_csf_builder_core regression: fail");
            $finish;
         end
      end
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Builds a request with random filler in the fields the command does not use.
   function req_type make_req(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] c0,
                              logic [WORD_W-1:0] c1, logic [WORD_W-1:0] c2,
                              logic [LEVEL_W-1:0] lvl, logic kind, logic [POS_W-1:0] pos);
      req_type t;
      logic [127:0] filler;
      filler = {$urandom, $urandom, $urandom, $urandom};
      t = filler[$bits(req_type)-1:0];
      t.command = cmd;
      if (cmd == CMD_APPEND) begin
         t.coord_0 = c0;
         t.coord_1 = c1;
         t.coord_2 = c2;
      end
      if (cmd == CMD_READ) begin
         t.read_level = lvl;
         t.read_kind = kind;
         t.read_position = pos;
      end
      return t;
   endfunction

   // Drives one request transaction and waits until it is accepted.
   task send(req_type t);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      sb.note(t);
      items_sent++;
   endtask

   // Writes the mode count once everything in flight has come back.
   task set_mode(logic [MODE_W-1:0] value);
      req_valid <= 0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.mode_reg = value;
   endtask

   function logic [WORD_W-1:0] rand_coord(bit narrow);
      if (narrow && $urandom_range(0, 3) != 0) return $urandom_range(0, 3);
      return $urandom;
   endfunction

   // Appends with random content; late appends keep mode 0 mostly ascending
   // so that builds over a full store stay short.
   task send_append(bit ascending);
      logic [WORD_W-1:0] c0;
      if (ascending) begin
         if ($urandom_range(0, 2) != 0 || row_counter == 0) begin
            row_counter = row_counter + 22'd1;
            last_row = {row_counter, 10'($urandom)};
         end
         c0 = last_row;
      end else begin
         c0 = rand_coord(1);
      end
      send(make_req(CMD_APPEND, c0, rand_coord(1), rand_coord(1), 0, 0, 0));
   endtask

   // Reads mostly within or just past the selected array, sometimes anywhere or at extreme positions.
   task send_read();
      logic [LEVEL_W-1:0] lvl;
      logic kind;
      int r;
      int pos;
      lvl = LEVEL_W'($urandom_range(0, 3));
      kind = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 75) pos = $urandom_range(0, sb.array_len(lvl, kind) + 1);
      else if (r < 90) pos = $urandom_range(0, 2047);
      else pos = ($urandom_range(0, 1) != 0) ? 2047 : $urandom_range(1023, 1025);
      send(make_req(CMD_READ, 0, 0, 0, lvl, kind, POS_W'(pos)));
   endtask

   // One random transaction; builds get rarer as the store grows.
   task send_random(bit ascending);
      int r;
      r = $urandom_range(0, 99);
      if (sb.loaded < STORE_DEPTH ? r < 55 : r < 15) send_append(ascending);
      else if (r < 94) send_read();
      else if (r < 97 && (sb.loaded <= 300 || $urandom_range(0, 3) == 0))
         send(make_req(CMD_BUILD, 0, 0, 0, 0, 0, 0));
      else send(make_req(CMD_NOP, 0, 0, 0, 0, 0, 0));
   endtask

   logic [MODE_W-1:0] phase_modes [6] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd2};
   localparam logic [WORD_W-1:0] ONES = '1;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: read before build, empty build, extremes, duplicates, ignored command.
      send(make_req(CMD_READ, 0, 0, 0, 0, KIND_PTR, 0));
      send(make_req(CMD_BUILD, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_READ, 0, 0, 0, 0, KIND_PTR, 0));
      send(make_req(CMD_READ, 0, 0, 0, 0, KIND_PTR, 1));
      send(make_req(CMD_READ, 0, 0, 0, 0, KIND_PTR, 2));
      send(make_req(CMD_READ, 0, 0, 0, 1, KIND_PTR, 0));
      send(make_req(CMD_READ, 0, 0, 0, 0, KIND_IDX, 0));
      send(make_req(CMD_READ, 0, 0, 0, 3, KIND_PTR, 0));
      send(make_req(CMD_APPEND, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_APPEND, ONES, ONES, ONES, 0, 0, 0));
      send(make_req(CMD_APPEND, ONES, ONES, ONES, 0, 0, 0));
      send(make_req(CMD_APPEND, 0, 1, 2, 0, 0, 0));
      send(make_req(CMD_APPEND, 0, 1, 0, 0, 0, 0));
      send(make_req(CMD_NOP, 0, 0, 0, 0, 0, 0));
      send(make_req(CMD_BUILD, 0, 0, 0, 0, 0, 0));
      for (int p = 0; p < 4; p++) send(make_req(CMD_READ, 0, 0, 0, 0, KIND_IDX, POS_W'(p)));
      for (int p = 0; p < 4; p++) send(make_req(CMD_READ, 0, 0, 0, 1, KIND_PTR, POS_W'(p)));
      send(make_req(CMD_READ, 0, 0, 0, 2, KIND_IDX, 1));
      send(make_req(CMD_READ, 0, 0, 0, 0, KIND_PTR, 2047));

      // Random phases over several mode counts; the fourth one fills the store.
      for (int ph = 0; ph < 6; ph++) begin
         set_mode(phase_modes[ph]);
         if (ph == 3) begin
            while (sb.loaded < STORE_DEPTH) begin
               if (items_sent % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
               if ($urandom_range(0, 9) != 0) send_append(1);
               else send_read();
            end
         end
         if (ph >= 3) send(make_req(CMD_BUILD, 0, 0, 0, 0, 0, 0));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_random(ph >= 3);
         end
      end

      // Drain, then let the pipeline settle.
      req_valid <= 0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d transactions and checked %0d responses.", items_sent, sb.checked);
      $display("Covered %0d builds, %0d dropped appends, mode counts 0 to 3.",
               sb.builds, sb.drops);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("coo_to_csf_builder_core regression: pass");
      else
         $display("coo_to_csf_builder_core regression: fail");
      $finish;
   end

endmodule

// File: files.f
hdl/ctsb_pkg.sv
hdl/ctsb_ram.sv
hdl/ctsb_key_cmp.sv
hdl/coo_to_csf_builder_core.sv
hdl/ctsb_checker.sv
tb/coo_to_csf_builder_core_test.sv
